// ===== rtl/lav_pkg.sv =====
// Shared types and constants for the look-at view matrix block.
// No dependencies; every rtl file imports this package.
package lav_pkg;

    // Latency of one vector normalizer, input to registered output.
    localparam int NORM_LAT  = 71;
    localparam int ISQ_STEPS = 32;
    localparam int DIV_STEPS = 31;

    // One half in Q2.30 (rounding constant for Q4.60 -> Q2.30).
    localparam logic [63:0] HALF30 = 64'd536870912;

    typedef logic [2:0][62:0] vec63_t;
    typedef logic [2:0][31:0] vec32_t;

    typedef struct packed {
        logic        right_handed;
        logic [31:0] eye_x;
        logic [31:0] eye_y;
        logic [31:0] eye_z;
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [31:0] target_z;
        logic [31:0] up_x;
        logic [31:0] up_y;
        logic [31:0] up_z;
    } in_t;

    typedef struct packed {
        logic [31:0] xaxis_x;
        logic [31:0] xaxis_y;
        logic [31:0] xaxis_z;
        logic [31:0] yaxis_x;
        logic [31:0] yaxis_y;
        logic [31:0] yaxis_z;
        logic [31:0] zaxis_x;
        logic [31:0] zaxis_y;
        logic [31:0] zaxis_z;
        logic [31:0] shift_x;
        logic [31:0] shift_y;
        logic [31:0] shift_z;
    } out_t;

endpackage

// ===== rtl/lav_norm.sv =====
// Pipelined 3-vector normalizer: scale, sum of squares, bit-serial
// square root and restoring division, one bit per stage. Uses lav_pkg.
module lav_norm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  lav_pkg::vec63_t in_vec,
    output logic            out_valid,
    output lav_pkg::vec32_t out_vec
);
    import lav_pkg::*;

    typedef struct packed {
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
    } side_t;

    logic [NORM_LAT:1] vld_reg;

    // stage 1: magnitudes and largest one
    logic [2:0][62:0] mag_next, mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]       neg_next, neg1_reg, neg2_reg, neg3_reg;
    logic [62:0]      big_next, big1_reg;
    // stage 2/3: leading-one search
    logic [7:0]       gnz_next, gnz2_reg;
    logic [7:0][2:0]  gpos_next, gpos2_reg;
    logic [5:0]       pos_next, pos3_reg;
    logic             zero_next, zero3_reg;
    // stage 4..6: scale, square, sum
    logic [2:0][29:0] m_next;
    side_t            side4_reg, side5_reg, side6_reg;
    logic [2:0][59:0] sq5_reg;
    logic [61:0]      sum6_reg;
    // square root
    logic [63:0]      isq_s_next [1:ISQ_STEPS];
    logic [63:0]      isq_s_reg  [1:ISQ_STEPS];
    logic [63:0]      isq_r_next [1:ISQ_STEPS];
    logic [63:0]      isq_r_reg  [1:ISQ_STEPS];
    side_t            isq_sd_reg [1:ISQ_STEPS];
    // division
    logic [2:0][60:0] div_rem_next [1:DIV_STEPS];
    logic [2:0][60:0] div_rem_reg  [0:DIV_STEPS];
    logic [2:0][30:0] div_q_next   [1:DIV_STEPS];
    logic [2:0][30:0] div_q_reg    [0:DIV_STEPS];
    logic [30:0]      div_len_reg  [0:DIV_STEPS];
    side_t            div_sd_reg   [0:DIV_STEPS];
    logic [30:0]      len_w;
    logic [2:0][60:0] num_next;
    vec32_t           out_next, out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = in_vec[i][62];
            mag_next[i] = in_vec[i][62] ? (~in_vec[i] + 63'd1) : in_vec[i];
        end
        big_next = mag_next[0];
        if (mag_next[1] > big_next) big_next = mag_next[1];
        if (mag_next[2] > big_next) big_next = mag_next[2];
    end

    always_comb begin
        logic [63:0] b64;
        b64 = {1'b0, big1_reg};
        for (int g = 0; g < 8; g++) begin
            gnz_next[g]  = |b64[8*g +: 8];
            gpos_next[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (b64[8*g + b]) gpos_next[g] = 3'(b);
            end
        end
    end

    always_comb begin
        pos_next = '0;
        for (int g = 0; g < 8; g++) begin
            if (gnz2_reg[g]) pos_next = {3'(g), gpos2_reg[g]};
        end
        zero_next = ~|gnz2_reg;
    end

    // bring the largest magnitude into [2^29, 2^30); truncate the others
    always_comb begin
        logic [62:0] t;
        logic [5:0]  amt;
        for (int i = 0; i < 3; i++) begin
            if (pos3_reg >= 6'd29) begin
                amt = pos3_reg - 6'd29;
                t   = mag3_reg[i] >> amt;
            end else begin
                amt = 6'd29 - pos3_reg;
                t   = mag3_reg[i] << amt;
            end
            m_next[i] = t[29:0];
        end
    end

    genvar k;
    for (k = 0; k < ISQ_STEPS; k++) begin : g_isq
        localparam logic [63:0] ONE = 64'd1 << (62 - 2 * k);
        logic [63:0] s_in, r_in, t;
        if (k == 0) begin : g_first
            assign s_in = {2'b00, sum6_reg};
            assign r_in = '0;
        end else begin : g_rest
            assign s_in = isq_s_reg[k];
            assign r_in = isq_r_reg[k];
        end
        assign t = r_in + ONE;
        always_comb begin
            if (s_in >= t) begin
                isq_s_next[k+1] = s_in - t;
                isq_r_next[k+1] = (r_in >> 1) + ONE;
            end else begin
                isq_s_next[k+1] = s_in;
                isq_r_next[k+1] = r_in >> 1;
            end
        end
    end

    assign len_w = isq_r_reg[ISQ_STEPS][30:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = {1'b0, isq_sd_reg[ISQ_STEPS].m[i], 30'd0}
                        + 61'(len_w >> 1);
        end
    end

    for (k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - k;
        logic [61:0] trial;
        assign trial = 62'(div_len_reg[k]) << BIT;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                div_q_next[k+1][i] = div_q_reg[k][i];
                if ({1'b0, div_rem_reg[k][i]} >= trial) begin
                    div_rem_next[k+1][i] = div_rem_reg[k][i] - trial[60:0];
                    div_q_next[k+1][i][BIT] = 1'b1;
                end else begin
                    div_rem_next[k+1][i] = div_rem_reg[k][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (div_sd_reg[DIV_STEPS].zero) begin
                out_next[i] = '0;
            end else if (div_sd_reg[DIV_STEPS].neg[i]) begin
                out_next[i] = ~{1'b0, div_q_reg[DIV_STEPS][i]} + 32'd1;
            end else begin
                out_next[i] = {1'b0, div_q_reg[DIV_STEPS][i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NORM_LAT-1:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag_next;
            neg1_reg  <= neg_next;
            big1_reg  <= big_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            gnz2_reg  <= gnz_next;
            gpos2_reg <= gpos_next;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            pos3_reg  <= pos_next;
            zero3_reg <= zero_next;
            side4_reg <= '{m: m_next, neg: neg3_reg, zero: zero3_reg};
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= 60'(side4_reg.m[i]) * 60'(side4_reg.m[i]);
            end
            side5_reg <= side4_reg;
            sum6_reg  <= 62'(sq5_reg[0]) + 62'(sq5_reg[1]) + 62'(sq5_reg[2]);
            side6_reg <= side5_reg;
            isq_s_reg <= isq_s_next;
            isq_r_reg <= isq_r_next;
            isq_sd_reg[1] <= side6_reg;
            for (int j = 2; j <= ISQ_STEPS; j++) isq_sd_reg[j] <= isq_sd_reg[j-1];
            div_rem_reg[0] <= num_next;
            div_q_reg[0]   <= '0;
            div_len_reg[0] <= len_w;
            div_sd_reg[0]  <= isq_sd_reg[ISQ_STEPS];
            for (int j = 1; j <= DIV_STEPS; j++) begin
                div_rem_reg[j] <= div_rem_next[j];
                div_q_reg[j]   <= div_q_next[j];
                div_len_reg[j] <= div_len_reg[j-1];
                div_sd_reg[j]  <= div_sd_reg[j-1];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[NORM_LAT];
    assign out_vec   = out_reg;

endmodule

// ===== rtl/look_at_view_matrix_top.sv =====
// Look-at view matrix: z, x and y axes and the translation row, fully pipelined.
// Depends on lav_pkg and lav_norm.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | lav_pkg::in_t  s_data
//  m_      | out       | m_valid / m_ready  | lav_pkg::out_t m_data
//
// One request enters per cycle unless the pipeline holds.
// Latency is set by the two normalizers in series (square root and divide, one bit
// per stage). The whole pipeline holds while the output register is full and not taken.
// Reset clears only valid bits; data registers are not reset.
module look_at_view_matrix_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lav_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lav_pkg::out_t m_data
);
    import lav_pkg::*;

    function automatic logic [63:0] smul(input logic [31:0] a, input logic [31:0] b);
        return $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    endfunction

    // Q4.60 -> Q2.30, halves away from zero, saturate
    function automatic logic [31:0] round_q30(input logic [63:0] v);
        logic        neg;
        logic [63:0] mg;
        logic [34:0] q;
        neg = v[63];
        mg  = neg ? (~v + 64'd1) : v;
        q   = 35'((mg + HALF30) >> 30);
        if (!neg) begin
            return (q > 35'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        end
        return (q > 35'h80000000) ? 32'h80000000 : (~q[31:0] + 32'd1);
    endfunction

    // -floor((p0 + p1 + p2 + half) / 2^30), saturated
    function automatic logic [31:0] neg_dot(input logic [63:0] p0, input logic [63:0] p1,
                                            input logic [63:0] p2);
        logic signed [65:0] s;
        logic signed [36:0] n;
        s = $signed({{2{p0[63]}}, p0}) + $signed({{2{p1[63]}}, p1})
          + $signed({{2{p2[63]}}, p2}) + $signed({2'b00, HALF30});
        n = -$signed({s[65], s[65:30]});
        if (n > $signed(37'sh07FFFFFFF)) return 32'h7FFFFFFF;
        if (n < $signed(-37'sh080000000)) return 32'h80000000;
        return n[31:0];
    endfunction

    logic   en;
    in_t    in_reg;
    logic   v0_reg;
    vec32_t eye0, up0;
    logic [2:0][32:0] d0;
    vec63_t up_w, d_w;
    logic   nu_valid, nd_valid, nx_valid;
    vec32_t upn, zn, xn;

    vec32_t eyea_reg [1:NORM_LAT];
    vec32_t eyeb_reg [1:NORM_LAT];
    vec32_t zb_reg   [1:NORM_LAT];

    logic [63:0] c1_p_reg [0:5];
    vec32_t      c1_z_reg, c1_eye_reg;
    logic        c1_v_reg;
    vec63_t      c2_xr_reg;
    vec32_t      c2_z_reg, c2_eye_reg;
    logic        c2_v_reg;

    logic [63:0] y1_p_reg [0:5];
    vec32_t      y1_x_reg, y1_z_reg, y1_eye_reg;
    logic        y1_v_reg;
    vec32_t      y2_x_reg, y2_y_reg, y2_z_reg, y2_eye_reg;
    logic        y2_v_reg;
    logic [63:0] d1_p_reg [0:8];
    vec32_t      d1_x_reg, d1_y_reg, d1_z_reg;
    logic        d1_v_reg;

    logic [63:0] xr_w [0:2];
    logic [63:0] yr_w [0:2];
    out_t        m_data_next, m_data_reg;
    logic        m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign eye0 = {in_reg.eye_z, in_reg.eye_y, in_reg.eye_x};
    assign up0  = {in_reg.up_z, in_reg.up_y, in_reg.up_x};

    always_comb begin
        logic [2:0][32:0] e, t;
        e = {{in_reg.eye_z[31], in_reg.eye_z}, {in_reg.eye_y[31], in_reg.eye_y},
             {in_reg.eye_x[31], in_reg.eye_x}};
        t = {{in_reg.target_z[31], in_reg.target_z}, {in_reg.target_y[31], in_reg.target_y},
             {in_reg.target_x[31], in_reg.target_x}};
        for (int i = 0; i < 3; i++) begin
            d0[i]   = in_reg.right_handed ? (e[i] - t[i]) : (t[i] - e[i]);
            up_w[i] = {{31{up0[i][31]}}, up0[i]};
            d_w[i]  = {{30{d0[i][32]}}, d0[i]};
        end
    end

    lav_norm u_norm_up (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg), .in_vec(up_w),
        .out_valid(nu_valid), .out_vec(upn)
    );

    lav_norm u_norm_z (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg), .in_vec(d_w),
        .out_valid(nd_valid), .out_vec(zn)
    );

    lav_norm u_norm_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c2_v_reg), .in_vec(c2_xr_reg),
        .out_valid(nx_valid), .out_vec(xn)
    );

    assign xr_w[0] = c1_p_reg[0] - c1_p_reg[1];
    assign xr_w[1] = c1_p_reg[2] - c1_p_reg[3];
    assign xr_w[2] = c1_p_reg[4] - c1_p_reg[5];
    assign yr_w[0] = y1_p_reg[0] - y1_p_reg[1];
    assign yr_w[1] = y1_p_reg[2] - y1_p_reg[3];
    assign yr_w[2] = y1_p_reg[4] - y1_p_reg[5];

    always_comb begin
        m_data_next.xaxis_x = d1_x_reg[0];
        m_data_next.xaxis_y = d1_x_reg[1];
        m_data_next.xaxis_z = d1_x_reg[2];
        m_data_next.yaxis_x = d1_y_reg[0];
        m_data_next.yaxis_y = d1_y_reg[1];
        m_data_next.yaxis_z = d1_y_reg[2];
        m_data_next.zaxis_x = d1_z_reg[0];
        m_data_next.zaxis_y = d1_z_reg[1];
        m_data_next.zaxis_z = d1_z_reg[2];
        m_data_next.shift_x = neg_dot(d1_p_reg[0], d1_p_reg[1], d1_p_reg[2]);
        m_data_next.shift_y = neg_dot(d1_p_reg[3], d1_p_reg[4], d1_p_reg[5]);
        m_data_next.shift_z = neg_dot(d1_p_reg[6], d1_p_reg[7], d1_p_reg[8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            c1_v_reg    <= 1'b0;
            c2_v_reg    <= 1'b0;
            y1_v_reg    <= 1'b0;
            y2_v_reg    <= 1'b0;
            d1_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_valid;
            c1_v_reg    <= nu_valid && nd_valid;
            c2_v_reg    <= c1_v_reg;
            y1_v_reg    <= nx_valid;
            y2_v_reg    <= y1_v_reg;
            d1_v_reg    <= y2_v_reg;
            m_valid_reg <= d1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
            // align eye with the first pair of normalizers
            eyea_reg[1] <= eye0;
            for (int j = 2; j <= NORM_LAT; j++) eyea_reg[j] <= eyea_reg[j-1];

            // x raw = up_n cross z
            c1_p_reg[0] <= smul(upn[1], zn[2]);
            c1_p_reg[1] <= smul(upn[2], zn[1]);
            c1_p_reg[2] <= smul(upn[2], zn[0]);
            c1_p_reg[3] <= smul(upn[0], zn[2]);
            c1_p_reg[4] <= smul(upn[0], zn[1]);
            c1_p_reg[5] <= smul(upn[1], zn[0]);
            c1_z_reg    <= zn;
            c1_eye_reg  <= eyea_reg[NORM_LAT];
            for (int i = 0; i < 3; i++) c2_xr_reg[i] <= xr_w[i][62:0];
            c2_z_reg    <= c1_z_reg;
            c2_eye_reg  <= c1_eye_reg;

            // hold z and eye alongside the x normalizer
            zb_reg[1]   <= c2_z_reg;
            eyeb_reg[1] <= c2_eye_reg;
            for (int j = 2; j <= NORM_LAT; j++) begin
                zb_reg[j]   <= zb_reg[j-1];
                eyeb_reg[j] <= eyeb_reg[j-1];
            end

            // y raw = z cross x
            y1_p_reg[0] <= smul(zb_reg[NORM_LAT][1], xn[2]);
            y1_p_reg[1] <= smul(zb_reg[NORM_LAT][2], xn[1]);
            y1_p_reg[2] <= smul(zb_reg[NORM_LAT][2], xn[0]);
            y1_p_reg[3] <= smul(zb_reg[NORM_LAT][0], xn[2]);
            y1_p_reg[4] <= smul(zb_reg[NORM_LAT][0], xn[1]);
            y1_p_reg[5] <= smul(zb_reg[NORM_LAT][1], xn[0]);
            y1_x_reg    <= xn;
            y1_z_reg    <= zb_reg[NORM_LAT];
            y1_eye_reg  <= eyeb_reg[NORM_LAT];

            for (int i = 0; i < 3; i++) y2_y_reg[i] <= round_q30(yr_w[i]);
            y2_x_reg   <= y1_x_reg;
            y2_z_reg   <= y1_z_reg;
            y2_eye_reg <= y1_eye_reg;

            for (int i = 0; i < 3; i++) begin
                d1_p_reg[i]     <= smul(y2_x_reg[i], y2_eye_reg[i]);
                d1_p_reg[3 + i] <= smul(y2_y_reg[i], y2_eye_reg[i]);
                d1_p_reg[6 + i] <= smul(y2_z_reg[i], y2_eye_reg[i]);
            end
            d1_x_reg <= y2_x_reg;
            d1_y_reg <= y2_y_reg;
            d1_z_reg <= y2_z_reg;

            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a zero z axis forces zero x and y axes
    a_zero_z: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.zaxis_x == 32'd0 && m_data.zaxis_y == 32'd0 &&
         m_data.zaxis_z == 32'd0) |->
        (m_data.xaxis_x == 32'd0 && m_data.xaxis_y == 32'd0 && m_data.xaxis_z == 32'd0 &&
         m_data.yaxis_x == 32'd0 && m_data.yaxis_y == 32'd0 && m_data.yaxis_z == 32'd0))
        else $error("nonzero x or y axis with zero z axis");

    // the x components of the z and x axes stay within one in Q2.30
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        ($signed(m_data.zaxis_x) <= 32'sh40000000 && $signed(m_data.zaxis_x) >= -32'sh40000000 &&
         $signed(m_data.xaxis_x) <= 32'sh40000000 && $signed(m_data.xaxis_x) >= -32'sh40000000))
        else $error("unit axis component out of range");

    // the two front normalizers run in lockstep
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        nu_valid == nd_valid)
        else $error("front normalizers out of step");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for look_at_view_matrix_top: directed camera setups, then random ones.
// Depends on lav_pkg and RTL; checked against a fixed-point look-at predictor or set views.
module tb;
    import lav_pkg::*;

    localparam longint ONE16 = 64'sd65536;
    localparam longint ONE30 = 64'sd1073741824;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    typedef struct {
        in_t  req;
        bit   typed;
        out_t res;
    } row_t;

    out_t  views_due[$];
    row_t  rows[$];
    int    errors = 0;
    bit    calm = 1'b0;

    always #10 aclk = ~aclk;

    look_at_view_matrix_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(input longint v[3], output longint o[3]);
        longint unsigned m[3], big, sum, len, qq;
        int sh;
        big = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (big >= (64'd1 << 30)) begin big = big >> 1; sh--; end
        while (big < (64'd1 << 29)) begin big = big << 1; sh++; end
        for (int i = 0; i < 3; i++) begin
            if (sh < 0) m[i] = m[i] >> (-sh);
            else m[i] = m[i] << sh;
            sum = sum + m[i] * m[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            qq = ((m[i] << 30) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -longint'(qq) : longint'(qq);
        end
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint q60_to_q30(longint v);
        longint unsigned mg;
        longint q;
        mg = v < 0 ? -v : v;
        q = longint'((mg + (64'd1 << 29)) >> 30);
        return clamp32(v < 0 ? -q : q);
    endfunction

    // Exact sum of Q2.30 x Q16.16 products, rounded to Q16.16 and negated.
    function automatic longint eye_shift(input longint a[3], input longint e[3]);
        longint p, q, sq, sr, t;
        sq = 0;
        sr = 0;
        for (int i = 0; i < 3; i++) begin
            p = a[i] * e[i];
            q = p >>> 2;
            sq += q;
            sr += p - 4 * q;
        end
        t = sq + ((sr + (64'sd1 <<< 29)) >>> 2);
        return clamp32(-(t >>> 28));
    endfunction

    function automatic out_t view_of(in_t r);
        longint eye[3], tgt[3], up[3], dir[3], upn[3], z[3], xr[3], x[3], yr[3], y[3];
        longint sx, sy, sz;
        out_t o;
        eye[0] = longint'($signed(r.eye_x));
        eye[1] = longint'($signed(r.eye_y));
        eye[2] = longint'($signed(r.eye_z));
        tgt[0] = longint'($signed(r.target_x));
        tgt[1] = longint'($signed(r.target_y));
        tgt[2] = longint'($signed(r.target_z));
        up[0]  = longint'($signed(r.up_x));
        up[1]  = longint'($signed(r.up_y));
        up[2]  = longint'($signed(r.up_z));
        for (int i = 0; i < 3; i++)
            dir[i] = r.right_handed ? eye[i] - tgt[i] : tgt[i] - eye[i];
        unit_vec(up, upn);
        unit_vec(dir, z);
        cross3(upn, z, xr);
        unit_vec(xr, x);
        cross3(z, x, yr);
        for (int i = 0; i < 3; i++) y[i] = q60_to_q30(yr[i]);
        sx = eye_shift(x, eye);
        sy = eye_shift(y, eye);
        sz = eye_shift(z, eye);
        o.xaxis_x = x[0][31:0];
        o.xaxis_y = x[1][31:0];
        o.xaxis_z = x[2][31:0];
        o.yaxis_x = y[0][31:0];
        o.yaxis_y = y[1][31:0];
        o.yaxis_z = y[2][31:0];
        o.zaxis_x = z[0][31:0];
        o.zaxis_y = z[1][31:0];
        o.zaxis_z = z[2][31:0];
        o.shift_x = sx[31:0];
        o.shift_y = sy[31:0];
        o.shift_z = sz[31:0];
        return o;
    endfunction

    function automatic in_t setup(bit rh, longint ex, longint ey, longint ez,
                                  longint tx, longint ty, longint tz,
                                  longint ux, longint uy, longint uz);
        in_t r;
        r.right_handed = rh;
        r.eye_x = ex[31:0];
        r.eye_y = ey[31:0];
        r.eye_z = ez[31:0];
        r.target_x = tx[31:0];
        r.target_y = ty[31:0];
        r.target_z = tz[31:0];
        r.up_x = ux[31:0];
        r.up_y = uy[31:0];
        r.up_z = uz[31:0];
        return r;
    endfunction

    function automatic void add_row(in_t r, bit typed, out_t e);
        row_t w;
        w.req = r;
        w.typed = typed;
        w.res = e;
        rows.push_back(w);
    endfunction

    function automatic logic [31:0] any32();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7fffffff - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
        endcase
    endfunction

    // Random camera: mostly well-formed, some degenerate on purpose.
    function automatic in_t random_setup();
        in_t r;
        r.right_handed = 1'($urandom_range(0, 1));
        r.eye_x = any32();
        r.eye_y = any32();
        r.eye_z = any32();
        r.target_x = any32();
        r.target_y = any32();
        r.target_z = any32();
        r.up_x = any32();
        r.up_y = any32();
        r.up_z = any32();
        case ($urandom_range(0, 19))
            0: begin
                r.target_x = r.eye_x;
                r.target_y = r.eye_y;
                r.target_z = r.eye_z;
            end
            1: begin
                r.up_x = '0;
                r.up_y = '0;
                r.up_z = '0;
            end
            2: begin
                r.up_x = r.target_x - r.eye_x;
                r.up_y = r.target_y - r.eye_y;
                r.up_z = r.target_z - r.eye_z;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic chk(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    task automatic send(in_t r, bit typed, out_t e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        views_due.push_back(typed ? e : view_of(r));
    endtask

    // Drain results, with random back-pressure except while calm is set.
    initial begin
        int stall;
        out_t e;
        @(posedge aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (views_due.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = views_due.pop_front();
                chk("xaxis_x", e.xaxis_x, m_data.xaxis_x);
                chk("xaxis_y", e.xaxis_y, m_data.xaxis_y);
                chk("xaxis_z", e.xaxis_z, m_data.xaxis_z);
                chk("yaxis_x", e.yaxis_x, m_data.yaxis_x);
                chk("yaxis_y", e.yaxis_y, m_data.yaxis_y);
                chk("yaxis_z", e.yaxis_z, m_data.yaxis_z);
                chk("zaxis_x", e.zaxis_x, m_data.zaxis_x);
                chk("zaxis_y", e.zaxis_y, m_data.zaxis_y);
                chk("zaxis_z", e.zaxis_z, m_data.zaxis_z);
                chk("shift_x", e.shift_x, m_data.shift_x);
                chk("shift_y", e.shift_y, m_data.shift_y);
                chk("shift_z", e.shift_z, m_data.shift_z);
            end
        end
    end

    initial begin
        out_t zero, ident;
        longint mx, mn;
        zero = '0;
        ident = '0;
        ident.xaxis_x = ONE30[31:0];
        ident.yaxis_y = ONE30[31:0];
        ident.zaxis_z = ONE30[31:0];
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;

        add_row(setup(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero);
        add_row(setup(1, 0, 0, 0, 0, 0, 0, 0, ONE16, 0), 1, zero);
        add_row(setup(0, mx, mn, mx, mx, mn, mx, 0, ONE16, 0), 1, zero);
        add_row(setup(0, 0, 0, 0, 0, 0, ONE16, 0, ONE16, 0), 1, ident);
        add_row(setup(1, 0, 0, 0, 0, 0, -ONE16, 0, ONE16, 0), 1, ident);
        add_row(setup(0, 0, 0, 0, 0, 0, ONE16, 0, 0, 0), 0, zero);
        add_row(setup(1, 0, 0, 0, 0, 0, ONE16, 0, 0, ONE16), 0, zero);
        add_row(setup(0, 3 * ONE16, 2 * ONE16, -5 * ONE16, 0, 0, 0, 0, ONE16, 0), 0, zero);
        add_row(setup(1, 3 * ONE16, 2 * ONE16, -5 * ONE16, 0, 0, 0, 0, ONE16, 0), 0, zero);
        add_row(setup(0, mx, mx, mx, mn, mn, mn, mx, mx, mn), 0, zero);
        add_row(setup(1, mn, mn, mn, mx, mx, mx, mn, mn, mx), 0, zero);
        add_row(setup(0, mn, mx, mn, mx, mn, mx, mn, mx, mn), 0, zero);
        add_row(setup(1, mx, mn, 0, mn, mx, 0, mn, mn, mn), 0, zero);
        add_row(setup(0, mn, mn, mn, 0, 0, 0, 0, 0, mx), 0, zero);
        add_row(setup(0, 1, -1, 1, -1, 1, 0, 1, 1, 1), 0, zero);
        add_row(setup(1, mx, mx, mx, mx - 1, mx, mx, 0, 1, 0), 0, zero);
        add_row(setup(0, mn, mn, mn, mx, mx, mx, mx, mx, mx), 0, zero);
        add_row(setup(0, 0, 0, 0, 1, 2, 3, -1, -2, -3), 0, zero);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].res);
        for (int n = 0; n < 1600; n++) begin
            if (n % 200 == 0) calm = ($urandom_range(0, 2) == 0);
            send(random_setup(), 0, zero);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        wait (views_due.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
